// ===== rtl/mfqs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfqs_pkg
// Types, codes and defaults shared by the feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfqs_pkg;

    localparam int DEF_LEVELS      = 4;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;
    localparam int DEF_SLICE_BITS  = 16;

    localparam int CFG_SLICE_W = 16;
    localparam int CFG_SLICES  = 4;
    localparam int OP_W        = 2;
    localparam int EV_W        = 3;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;

    localparam logic [CFG_SLICE_W-1:0] RST_RR_SLICE = 16'd4;
    localparam logic [CFG_SLICE_W-1:0] RST_SLICE0   = 16'd1;
    localparam logic [CFG_SLICE_W-1:0] RST_SLICE1   = 16'd2;
    localparam logic [CFG_SLICE_W-1:0] RST_SLICE2   = 16'd4;
    localparam logic [CFG_SLICE_W-1:0] RST_SLICE3   = 16'd8;

    typedef enum logic [OP_W-1:0] {
        OP_ADMIT  = 2'd0,
        OP_TICK   = 2'd1,
        OP_RETIRE = 2'd2
    } t_op;

    typedef enum logic [EV_W-1:0] {
        EV_NONE     = 3'd0,
        EV_DISPATCH = 3'd1,
        EV_PREEMPT  = 3'd2,
        EV_RETIRE   = 3'd3,
        EV_DROP     = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        POL_FCFS = 2'd0,
        POL_RR   = 2'd1,
        POL_MLFQ = 2'd2
    } t_policy;

    typedef enum logic [2:0] {
        REG_POLICY   = 3'd0,
        REG_RR_SLICE = 3'd1,
        REG_SLICE0   = 3'd2,
        REG_SLICE1   = 3'd3,
        REG_SLICE2   = 3'd4,
        REG_SLICE3   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]                                  policy;
        logic [CFG_SLICE_W-1:0]                      rr_slice;
        logic [CFG_SLICES-1:0][CFG_SLICE_W-1:0]      level_slice;
    } t_cfg;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

endpackage

// ===== rtl/mfqs_in_if.sv =====
// ----------------------------------------------------------------------------
// mfqs_in_if
// Request channel: operation and task id with valid/ready.
// ----------------------------------------------------------------------------
interface mfqs_in_if #(
    parameter int ID_BITS = 8
);
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [ID_BITS-1:0] task_id;

    modport source (output valid, output operation, output task_id, input ready);
    modport sink   (input valid, input operation, input task_id, output ready);
endinterface

// ===== rtl/mfqs_out_if.sv =====
// ----------------------------------------------------------------------------
// mfqs_out_if
// Result channel: running task, its level and the step event.
// ----------------------------------------------------------------------------
interface mfqs_out_if #(
    parameter int ID_BITS   = 8,
    parameter int PRIO_BITS = 2
);
    logic                 valid;
    logic                 ready;
    logic                 running_valid;
    logic [ID_BITS-1:0]   running_task;
    logic [PRIO_BITS-1:0] running_prio;
    logic [2:0]           event_code;

    modport source (output valid, output running_valid, output running_task,
                    output running_prio, output event_code, input ready);
    modport sink   (input valid, input running_valid, input running_task,
                    input running_prio, input event_code, output ready);
endinterface

// ===== rtl/mfqs_queue.sv =====
// ----------------------------------------------------------------------------
// mfqs_queue
// One ready queue level: circular store with head, tail and count.
// ----------------------------------------------------------------------------
module mfqs_queue
    import mfqs_pkg::*;
#(
    parameter int DEPTH   = DEF_QUEUE_DEPTH,
    parameter int ID_BITS = DEF_ID_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_q_ctl                         i_ctl,
    input  logic [ID_BITS-1:0]             i_push_data,
    output logic [ID_BITS-1:0]             o_head,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ID_BITS-1:0] r_store [DEPTH];
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_head  = (r_count == '0) ? i_push_data : r_store[r_head];
    assign o_count = r_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_ctl.pop) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_ctl.push && i_ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_store[r_tail] <= i_push_data;
        end
    end

endmodule

// ===== rtl/mfqs_core.sv =====
// ----------------------------------------------------------------------------
// mfqs_core
// Scheduling step: running slot, tick count, level pick and queue updates.
// ----------------------------------------------------------------------------
module mfqs_core
    import mfqs_pkg::*;
#(
    parameter int LEVELS      = DEF_LEVELS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int SLICE_BITS  = DEF_SLICE_BITS,
    parameter int LEVEL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_step,
    input  logic [OP_W-1:0]    i_op,
    input  logic [ID_BITS-1:0] i_task_id,
    output logic               o_running_valid,
    output logic [ID_BITS-1:0] o_running_task,
    output logic [LEVEL_W-1:0] o_running_prio,
    output t_event             o_event_code
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (SLICE_BITS > CFG_SLICE_W) ? SLICE_BITS : CFG_SLICE_W;
    localparam logic [SLICE_BITS-1:0] SLICE_MAX = '1;

    logic               r_valid, n_valid;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [SLICE_BITS-1:0] r_used, n_used;

    logic [CNT_W-1:0]   q_count [LEVELS];
    logic [ID_BITS-1:0] q_head  [LEVELS];
    t_q_ctl             q_ctl   [LEVELS];

    logic [LEVELS-1:0]  nonempty;
    logic [LEVELS-1:0]  full;
    logic [LEVELS-1:0]  pick_mask;
    logic [LEVEL_W-1:0] top_now;
    logic [LEVEL_W-1:0] pick_lvl;
    logic               pick_any;

    logic               push_en;
    logic [LEVEL_W-1:0] push_lvl;
    logic [ID_BITS-1:0] push_data;
    logic               disp;
    t_event             ev;

    logic [SLICE_BITS-1:0]  used_inc;
    logic [CFG_SLICE_W-1:0] slice;
    logic [LEVEL_W-1:0]     target;
    logic                   timed;
    logic [1:0]             slice_idx;

    function automatic logic [LEVEL_W-1:0] f_top(input logic [LEVELS-1:0] m);
        logic [LEVEL_W-1:0] r;
        r = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (m[l]) begin
                r = LEVEL_W'(l);
            end
        end
        return r;
    endfunction

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_lvl
            mfqs_queue #(
                .DEPTH   (QUEUE_DEPTH),
                .ID_BITS (ID_BITS)
            ) u_queue (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (q_ctl[g]),
                .i_push_data (push_data),
                .o_head      (q_head[g]),
                .o_count     (q_count[g])
            );
            assign nonempty[g]  = (q_count[g] != '0);
            assign full[g]      = (q_count[g] == CNT_W'(QUEUE_DEPTH));
            assign pick_mask[g] = nonempty[g] || (push_en && (push_lvl == LEVEL_W'(g)));
            assign q_ctl[g]     = {push_en && (push_lvl == LEVEL_W'(g)),
                                   disp && pick_any && (pick_lvl == LEVEL_W'(g))};
        end
    endgenerate

    assign top_now  = f_top(nonempty);
    assign pick_lvl = f_top(pick_mask);
    assign pick_any = |pick_mask;

    always_comb begin
        used_inc  = (r_used == SLICE_MAX) ? r_used : r_used + 1'b1;
        slice_idx = (int'(r_level) >= 3) ? 2'd3 : 2'(r_level);
        slice     = i_cfg.rr_slice;
        target    = '0;
        timed     = 1'b0;
        case (i_cfg.policy)
            POL_RR: begin
                slice = i_cfg.rr_slice;
                timed = 1'b1;
            end
            POL_MLFQ: begin
                slice  = i_cfg.level_slice[slice_idx];
                target = (int'(r_level) >= LEVELS - 1) ? LEVEL_W'(LEVELS - 1)
                                                       : r_level + 1'b1;
                timed  = 1'b1;
            end
            default: begin
                timed = 1'b0;
            end
        endcase
    end

    always_comb begin
        ev        = EV_NONE;
        push_en   = 1'b0;
        push_lvl  = '0;
        push_data = i_task_id;
        disp      = 1'b0;
        n_used    = r_used;
        if (i_step) begin
            case (i_op)
                OP_ADMIT: begin
                    if (full[0]) begin
                        ev = EV_DROP;
                    end else begin
                        push_en = 1'b1;
                        if (!r_valid) begin
                            disp = 1'b1;
                            ev   = EV_DISPATCH;
                        end
                    end
                end
                OP_TICK: begin
                    if (!r_valid) begin
                        if (|nonempty) begin
                            disp = 1'b1;
                            ev   = EV_DISPATCH;
                        end
                    end else begin
                        n_used = used_inc;
                        if (timed && (CMP_W'(used_inc) >= CMP_W'(slice))
                                && (!full[target] || (top_now == target))) begin
                            push_en   = 1'b1;
                            push_lvl  = target;
                            push_data = r_id;
                            disp      = 1'b1;
                            ev        = EV_PREEMPT;
                        end
                    end
                end
                OP_RETIRE: begin
                    if (r_valid) begin
                        disp = 1'b1;
                        ev   = EV_RETIRE;
                    end
                end
                default: begin
                    ev = EV_NONE;
                end
            endcase
        end
        if (disp) begin
            n_used = '0;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_level = r_level;
        if (disp) begin
            if (pick_any) begin
                n_valid = 1'b1;
                n_id    = q_head[pick_lvl];
                n_level = pick_lvl;
            end else begin
                n_valid = 1'b0;
                n_id    = '0;
                n_level = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_id    <= '0;
            r_level <= '0;
            r_used  <= '0;
        end else begin
            r_valid <= n_valid;
            r_id    <= n_id;
            r_level <= n_level;
            r_used  <= n_used;
        end
    end

    assign o_running_valid = n_valid;
    assign o_running_task  = n_id;
    assign o_running_prio  = n_level;
    assign o_event_code    = ev;

endmodule

// ===== rtl/multilevel_feedback_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Ready queues at several levels with FCFS, round robin and feedback policies.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request word: admit a task id into level 0, count one
//   tick for the running task, or retire it. o_out returns one result word
//   per request: running slot, its level and the event of that step.
//   The APB port holds policy and slice registers at byte address 4*index;
//   write them only while no request is in flight.
// Path: an accepted word goes from the request register through the core
//   into the result register, which drives o_out.
// Throughput: one word per cycle while o_out.ready holds; each step is one
//   priority pick plus at most one push and one pop on the level queues.
// Reset: queues empty, processor idle, registers at their default values.
//   No clearing pass; i_in.ready is high as soon as reset is released.
// Stall: while o_out.ready is low the result holds; one more request is
//   taken into the request register, then i_in.ready drops.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler
    import mfqs_pkg::*;
#(
    parameter int LEVELS      = DEF_LEVELS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int SLICE_BITS  = DEF_SLICE_BITS,
    parameter int LEVEL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mfqs_in_if.sink               i_in,
    mfqs_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg r_cfg;

    logic               r_in_valid;
    logic [OP_W-1:0]    r_op;
    logic [ID_BITS-1:0] r_task_id;

    logic               r_out_valid;
    logic               r_out_run;
    logic [ID_BITS-1:0] r_out_task;
    logic [LEVEL_W-1:0] r_out_prio;
    logic [EV_W-1:0]    r_out_ev;

    logic               advance;
    logic               step;
    logic               cfg_wr;
    t_reg_idx           reg_idx;

    logic               core_valid;
    logic [ID_BITS-1:0] core_task;
    logic [LEVEL_W-1:0] core_prio;
    t_event             core_ev;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy         <= POL_FCFS;
            r_cfg.rr_slice       <= RST_RR_SLICE;
            r_cfg.level_slice[0] <= RST_SLICE0;
            r_cfg.level_slice[1] <= RST_SLICE1;
            r_cfg.level_slice[2] <= RST_SLICE2;
            r_cfg.level_slice[3] <= RST_SLICE3;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_POLICY:   r_cfg.policy         <= pwdata[1:0];
                REG_RR_SLICE: r_cfg.rr_slice       <= pwdata[CFG_SLICE_W-1:0];
                REG_SLICE0:   r_cfg.level_slice[0] <= pwdata[CFG_SLICE_W-1:0];
                REG_SLICE1:   r_cfg.level_slice[1] <= pwdata[CFG_SLICE_W-1:0];
                REG_SLICE2:   r_cfg.level_slice[2] <= pwdata[CFG_SLICE_W-1:0];
                REG_SLICE3:   r_cfg.level_slice[3] <= pwdata[CFG_SLICE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_POLICY:   prdata = APB_DATA_W'(r_cfg.policy);
            REG_RR_SLICE: prdata = APB_DATA_W'(r_cfg.rr_slice);
            REG_SLICE0:   prdata = APB_DATA_W'(r_cfg.level_slice[0]);
            REG_SLICE1:   prdata = APB_DATA_W'(r_cfg.level_slice[1]);
            REG_SLICE2:   prdata = APB_DATA_W'(r_cfg.level_slice[2]);
            REG_SLICE3:   prdata = APB_DATA_W'(r_cfg.level_slice[3]);
            default:      prdata = '0;
        endcase
    end

    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op      <= i_in.operation;
            r_task_id <= i_in.task_id;
        end
        if (step) begin
            r_out_run  <= core_valid;
            r_out_task <= core_task;
            r_out_prio <= core_prio;
            r_out_ev   <= core_ev;
        end
    end

    mfqs_core #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .SLICE_BITS  (SLICE_BITS),
        .LEVEL_W     (LEVEL_W)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_step          (step),
        .i_op            (r_op),
        .i_task_id       (r_task_id),
        .o_running_valid (core_valid),
        .o_running_task  (core_task),
        .o_running_prio  (core_prio),
        .o_event_code    (core_ev)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.running_valid = r_out_run;
    assign o_out.running_task  = r_out_task;
    assign o_out.running_prio  = r_out_prio;
    assign o_out.event_code    = r_out_ev;

    a_idle_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_run) |-> (r_out_task == '0 && r_out_prio == '0))
        else $error("idle result carries a task");

    a_dispatch_runs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ev == EV_DISPATCH) |-> r_out_run)
        else $error("dispatch word without a running task");

    a_ready_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid && !o_out.ready))
        else $error("request side stalled without a full pipeline");

    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("step without a result word");

endmodule
